[src/ldwc_pkg.sv]
// Shared types, constants and the sine table builder for the luma-driven wave chroma block.
// No dependencies; every other file of the block imports this package.
package ldwc_pkg;

    // Sine table geometry: Q1.14 entries, phases in table-index units with 16 fraction bits
    localparam int SINE_DEPTH  = 1024;
    localparam int SINE_IDX_W  = $clog2(SINE_DEPTH);
    localparam int PHASE_W     = SINE_IDX_W + 16;
    localparam int WAVE_W      = 16;

    // Phase slopes: 0.05/(2*pi)*2^32 and 0.007/(2*pi)*2^32
    localparam logic [25:0] U_PHASE_K = 26'd34178264;
    localparam logic [22:0] V_PHASE_K = 23'd4784957;

    // Quarter turn offset for the cosine phase, D*16384
    localparam logic [PHASE_W-1:0] V_PHASE_QUARTER = PHASE_W'(SINE_DEPTH * 16384);

    // pi/2 in Q30 for the table builder
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_U_WAVE_GAIN = 2'd0,
        REG_V_WAVE_GAIN = 2'd1,
        REG_U_DIFF_GAIN = 2'd2,
        REG_V_DIFF_GAIN = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0]  luma_first;
        logic [7:0]  luma_second;
        logic [10:0] chroma_column;
        logic [11:0] luma_row;
    } t_in;

    typedef struct packed {
        logic [7:0] u_out;
        logic [7:0] v_out;
    } t_out;

    typedef struct packed {
        logic [7:0] u_wave_gain;
        logic [7:0] v_wave_gain;
        logic [8:0] u_diff_gain;
        logic [8:0] v_diff_gain;
    } t_gains;

    // Table lookup request leaving the phase pipeline
    typedef struct packed {
        logic                  valid;
        logic [SINE_IDX_W-1:0] u_idx;
        logic [SINE_IDX_W-1:0] v_idx;
        logic [8:0]            diff;
    } t_wave_req;

    // Operands entering the mixer
    typedef struct packed {
        logic [8:0]        diff;
        logic [WAVE_W-1:0] u_wave;
        logic [WAVE_W-1:0] v_wave;
    } t_mix_in;

    typedef logic [SINE_DEPTH-1:0][WAVE_W-1:0] t_sine_rom;

    // sin((pi/2)*m/D) in Q14, rounded, by a Q30 Taylor series (elaboration only)
    function automatic logic [WAVE_W-1:0] quarter_sine(input longint m);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = longint'((m * HALF_PI_Q30) / SINE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 12; n++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        return WAVE_W'((sum + 32768) >>> 16);
    endfunction

    // Full-turn table by quadrant folding
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        longint    t;
        longint    a;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            t = 4 * longint'(i);
            if (t <= SINE_DEPTH) begin
                a = t;
            end else if (t <= 3 * SINE_DEPTH) begin
                a = 2 * SINE_DEPTH - t;
            end else begin
                a = t - 4 * SINE_DEPTH;
            end
            if (a < 0) begin
                rom[i] = -quarter_sine(-a);
            end else begin
                rom[i] = quarter_sine(a);
            end
        end
        return rom;
    endfunction

endpackage

[src/ldwc_phase.sv]
// Phase pipeline: position and mean-luma phases for the sine and cosine lookups.
// Depends on ldwc_pkg; two register stages, table index produced from the second.
module ldwc_phase
    import ldwc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_in       i_data,
    output t_wave_req o_req
);

    // Stage one registers
    logic        r1_valid;
    logic [12:0] r1_pos_u;
    logic [14:0] r1_pos_v_mag;
    logic        r1_pos_v_neg;
    logic [8:0]  r1_sum;
    logic [8:0]  r1_diff;

    // Stage two registers
    logic               r2_valid;
    logic [PHASE_W-1:0] r2_u_lin;
    logic [PHASE_W-1:0] r2_v_lin;
    logic               r2_v_neg;
    logic [33:0]        r2_luma;
    logic [8:0]         r2_diff;

    logic [12:0] n1_pos_u;
    logic [15:0] ten_x;
    logic [15:0] three_r;
    logic [15:0] lin_v;
    logic [14:0] n1_pos_v_mag;
    logic [8:0]  n1_sum;
    logic [8:0]  n1_diff;

    logic [38:0] u_prod;
    logic [37:0] v_prod;
    logic [1:0]  luma_corr;
    logic [33:0] n2_luma;

    logic [PHASE_W-1:0] v_signed;
    logic [PHASE_W-1:0] u_phase;
    logic [PHASE_W-1:0] v_phase;

    // Position terms 2x+r and 10x-3r, luma sum and difference
    always_comb begin
        n1_pos_u     = {1'b0, i_data.chroma_column, 1'b0} + 13'(i_data.luma_row);
        ten_x        = (16'(i_data.chroma_column) << 3) + (16'(i_data.chroma_column) << 1);
        three_r      = (16'(i_data.luma_row) << 1) + 16'(i_data.luma_row);
        lin_v        = ten_x - three_r;
        n1_pos_v_mag = lin_v[15] ? 15'(-lin_v) : 15'(lin_v);
        n1_sum       = 9'(i_data.luma_first) + 9'(i_data.luma_second);
        n1_diff      = 9'(i_data.luma_first) - 9'(i_data.luma_second);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pos_u     <= n1_pos_u;
            r1_pos_v_mag <= n1_pos_v_mag;
            r1_pos_v_neg <= lin_v[15];
            r1_sum       <= n1_sum;
            r1_diff      <= n1_diff;
        end
    end

    // Slope products and sum/255 scaled by 2^32 via the 0x01010101 reciprocal
    always_comb begin
        u_prod    = 39'(r1_pos_u) * 39'(U_PHASE_K);
        v_prod    = 38'(r1_pos_v_mag) * 38'(V_PHASE_K);
        if (r1_sum >= 9'd510) begin
            luma_corr = 2'd2;
        end else if (r1_sum >= 9'd255) begin
            luma_corr = 2'd1;
        end else begin
            luma_corr = 2'd0;
        end
        n2_luma = 34'(r1_sum) + (34'(r1_sum) << 8) + (34'(r1_sum) << 16)
                + (34'(r1_sum) << 24) + 34'(luma_corr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_u_lin <= u_prod[32:7];
            r2_v_lin <= v_prod[31:6];
            r2_v_neg <= r1_pos_v_neg;
            r2_luma  <= n2_luma;
            r2_diff  <= r1_diff;
        end
    end

    // Wrap phases to the table and take the integer index
    always_comb begin
        v_signed = r2_v_neg ? -r2_v_lin : r2_v_lin;
        u_phase  = r2_u_lin + r2_luma[32:7];
        v_phase  = v_signed + r2_luma[33:8] + V_PHASE_QUARTER;
        o_req.valid = r2_valid;
        o_req.u_idx = u_phase[PHASE_W-1:16];
        o_req.v_idx = v_phase[PHASE_W-1:16];
        o_req.diff  = r2_diff;
    end

endmodule

[src/ldwc_sine_rom.sv]
// Dual-read sine table, Q1.14, with registered read data.
// Depends on ldwc_pkg for the table contents and geometry.
module ldwc_sine_rom
    import ldwc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [SINE_IDX_W-1:0] i_u_idx,
    input  logic [SINE_IDX_W-1:0] i_v_idx,
    output logic [WAVE_W-1:0]     o_u_wave,
    output logic [WAVE_W-1:0]     o_v_wave
);

    localparam t_sine_rom SINE_TABLE = build_sine_rom();

    logic [WAVE_W-1:0] r_u_wave;
    logic [WAVE_W-1:0] r_v_wave;

    // Read both ports, hold while the pipeline is held
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u_wave <= SINE_TABLE[i_u_idx];
            r_v_wave <= SINE_TABLE[i_v_idx];
        end
    end

    assign o_u_wave = r_u_wave;
    assign o_v_wave = r_v_wave;

endmodule

[src/ldwc_mix.sv]
// Mixer: scales luma difference and wave samples by the gains, sums and clamps.
// Depends on ldwc_pkg; one register stage of products, clamp on its output.
module ldwc_mix
    import ldwc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_mix_in i_mix,
    input  t_gains  i_gains,
    output logic    o_valid,
    output t_out    o_res
);

    logic               r4_valid;
    logic signed [10:0] r4_u_diff;
    logic signed [10:0] r4_u_wave;
    logic signed [10:0] r4_v_diff;
    logic signed [10:0] r4_v_wave;

    logic signed [24:0] u_wave_prod;
    logic signed [24:0] v_wave_prod;
    logic signed [18:0] u_diff_prod;
    logic signed [18:0] v_diff_prod;
    logic signed [12:0] u_sum;
    logic signed [12:0] v_sum;

    // Products; floor scaling is a slice of the two's complement bits
    always_comb begin
        u_wave_prod = $signed(i_mix.u_wave) * $signed({1'b0, i_gains.u_wave_gain});
        v_wave_prod = $signed(i_mix.v_wave) * $signed({1'b0, i_gains.v_wave_gain});
        u_diff_prod = $signed(i_mix.diff) * $signed({1'b0, i_gains.u_diff_gain});
        v_diff_prod = $signed(i_mix.diff) * $signed({1'b0, i_gains.v_diff_gain});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_u_wave <= u_wave_prod[24:14];
            r4_v_wave <= v_wave_prod[24:14];
            r4_u_diff <= u_diff_prod[18:8];
            r4_v_diff <= v_diff_prod[18:8];
        end
    end

    // Centre on 128, add waves and U's diff, subtract V's diff, clamp to 0..255
    always_comb begin
        u_sum = 13'sd128 + 13'(r4_u_diff) + 13'(r4_u_wave);
        v_sum = 13'sd128 - 13'(r4_v_diff) + 13'(r4_v_wave);
        if (u_sum < 0) begin
            o_res.u_out = 8'd0;
        end else if (u_sum > 13'sd255) begin
            o_res.u_out = 8'd255;
        end else begin
            o_res.u_out = u_sum[7:0];
        end
        if (v_sum < 0) begin
            o_res.v_out = 8'd0;
        end else if (v_sum > 13'sd255) begin
            o_res.v_out = 8'd255;
        end else begin
            o_res.v_out = v_sum[7:0];
        end
    end

    assign o_valid = r4_valid;

endmodule

[src/luma_driven_wave_chroma.sv]
// Top level of the luma-driven wave chroma synthesiser: config registers, pipeline, output skid.
// Depends on ldwc_pkg, ldwc_phase, ldwc_sine_rom and ldwc_mix.
//
//   channel   direction  handshake                    beat
//   input     in         i_valid / o_stall            t_in  (luma pair, column, row)
//   output    out        o_valid / i_stall            t_out (U and V sample)
//   config    in         i_cfg_valid / o_cfg_ready    register index and write data
//
// One beat per clock in and out while neither o_stall nor i_stall is raised. An accepted beat
// passes through two phase stages, the registered table read, the product stage and the output
// register to o_valid. Synchronous active-low reset clears valid bits and loads
// the gain reset values. o_stall is the registered skid-full flag: a stalled output keeps
// one more beat in the skid and then holds the whole pipeline until the output drains.
module luma_driven_wave_chroma
    import ldwc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  t_in                    i_data,
    output logic                   o_valid,
    input  logic                   i_stall,
    output t_out                   o_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_gains    r_gains;
    t_wave_req wave_req;
    t_mix_in   mix_in;
    t_out      mix_res;
    logic      mix_valid;

    logic              pipe_en;
    logic              out_take;
    logic              r_rom_valid;
    logic [8:0]        r_rom_diff;
    logic [WAVE_W-1:0] u_wave;
    logic [WAVE_W-1:0] v_wave;

    logic r_out_valid;
    t_out r_out_data;
    logic r_skid_valid;
    t_out r_skid_data;
    logic n_out_valid;
    t_out n_out_data;
    logic n_skid_valid;
    t_out n_skid_data;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.u_wave_gain <= 8'd100;
            r_gains.v_wave_gain <= 8'd120;
            r_gains.u_diff_gain <= 9'd204;
            r_gains.v_diff_gain <= 9'd256;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_U_WAVE_GAIN: r_gains.u_wave_gain <= i_cfg_data[7:0];
                REG_V_WAVE_GAIN: r_gains.v_wave_gain <= i_cfg_data[7:0];
                REG_U_DIFF_GAIN: r_gains.u_diff_gain <= i_cfg_data;
                REG_V_DIFF_GAIN: r_gains.v_diff_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the pipeline whenever the skid is empty
    assign pipe_en = ~r_skid_valid;
    assign o_stall = r_skid_valid;

    ldwc_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_req   (wave_req)
    );

    ldwc_sine_rom u_sine_rom (
        .i_clk    (i_clk),
        .i_en     (pipe_en),
        .i_u_idx  (wave_req.u_idx),
        .i_v_idx  (wave_req.v_idx),
        .o_u_wave (u_wave),
        .o_v_wave (v_wave)
    );

    // Carry valid and difference alongside the table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_valid <= 1'b0;
        end else if (pipe_en) begin
            r_rom_valid <= wave_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_rom_diff <= wave_req.diff;
        end
    end

    assign mix_in.diff   = r_rom_diff;
    assign mix_in.u_wave = u_wave;
    assign mix_in.v_wave = v_wave;

    ldwc_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r_rom_valid),
        .i_mix   (mix_in),
        .i_gains (r_gains),
        .o_valid (mix_valid),
        .o_res   (mix_res)
    );

    // Output register with one-beat skid
    assign out_take = r_out_valid & ~i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            if (out_take || !r_out_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (out_take || !r_out_valid) begin
            n_out_valid = mix_valid;
            n_out_data  = mix_res;
        end else if (mix_valid) begin
            n_skid_valid = 1'b1;
            n_skid_data  = mix_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

`ifndef SYNTH
    // Skid only holds a beat behind a waiting output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat with no output beat in front");

    // Skid fills only when the output was held
    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("skid filled while the output was free");

    // Held pipeline keeps its valid bits
    a_hold_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pipe_en |=> $stable(r_rom_valid) && $stable(mix_valid))
        else $error("pipeline moved while held");
`endif

endmodule

[tb/luma_driven_wave_chroma_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for luma_driven_wave_chroma: predicts U and V per beat in its own model.
// Depends on ldwc_pkg for the beat types and register indexes, and on the block itself.
module luma_driven_wave_chroma_tb;
    import ldwc_pkg::*;

    localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
    localparam longint U_SLOPE          = 64'sd34178264;
    localparam longint V_SLOPE          = 64'sd4784957;
    localparam longint PHASE_SPAN       = longint'(SINE_DEPTH) * 65536;
    localparam int     PHASES           = 6;
    localparam int     RANDOM_PER_PHASE = 215;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_valid     = 1'b0;
    logic                   o_stall;
    t_in                    i_data      = '0;
    logic                   o_valid;
    logic                   i_stall     = 1'b0;
    t_out                   o_data;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    // Gain copy, starting at the reset values
    logic [7:0] u_wave_gain = 8'd100;
    logic [7:0] v_wave_gain = 8'd120;
    logic [8:0] u_diff_gain = 9'd204;
    logic [8:0] v_diff_gain = 9'd256;

    int   wave_lut [SINE_DEPTH];
    t_in  pending_pairs [$];
    t_out expected_chroma [$];
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   mismatches    = 0;
    int   beats_sent    = 0;
    int   beats_checked = 0;
    int   beats_queued  = 0;

    luma_driven_wave_chroma dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // sin((pi/2)*m/D) in Q14, rounded, from a Q30 Taylor series
    function automatic int quarter_wave(longint m);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x    = longint'((m * QUARTER_TURN_Q30) / SINE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 12; n++) begin
            term = (term * x2) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        return int'((acc + 32768) >>> 16);
    endfunction

    // Fold the quarter wave into a full turn
    task automatic fill_wave_lut();
        longint t;
        longint a;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            t = 4 * longint'(i);
            if (t <= SINE_DEPTH) begin
                a = t;
            end else if (t <= 3 * SINE_DEPTH) begin
                a = 2 * SINE_DEPTH - t;
            end else begin
                a = t - 4 * SINE_DEPTH;
            end
            wave_lut[i] = (a < 0) ? -quarter_wave(-a) : quarter_wave(a);
        end
    endtask

    // Wrap a phase into one turn and read the table at its integer part
    function automatic longint wave_at(longint phase);
        longint p;
        p = phase % PHASE_SPAN;
        if (p < 0) begin
            p = p + PHASE_SPAN;
        end
        return longint'(wave_lut[p >>> 16]);
    endfunction

    function automatic logic [7:0] clamp_byte(longint v);
        if (v < 0) begin
            return 8'd0;
        end
        if (v > 255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    // U and V for one luma pair under the current gains
    function automatic t_out synth_chroma(t_in b);
        longint y1, y2, x, r, s, dl, pu, pv, lin, mag, u, v;
        t_out   res;
        y1  = longint'(b.luma_first);
        y2  = longint'(b.luma_second);
        x   = longint'(b.chroma_column);
        r   = longint'(b.luma_row);
        s   = y1 + y2;
        dl  = y1 - y2;
        pu  = (((2 * x + r) * U_SLOPE * SINE_DEPTH) >>> 17) + (s * PHASE_SPAN) / 510;
        lin = 10 * x - 3 * r;
        mag = (lin < 0) ? -lin : lin;
        mag = (mag * V_SLOPE * SINE_DEPTH) >>> 16;
        pv  = ((lin < 0) ? -mag : mag) + (s * PHASE_SPAN) / 1020 + longint'(SINE_DEPTH) * 16384;
        u   = 128 + ((dl * longint'(u_diff_gain)) >>> 8)
                  + ((wave_at(pu) * longint'(u_wave_gain)) >>> 14);
        v   = 128 - ((dl * longint'(v_diff_gain)) >>> 8)
                  + ((wave_at(pv) * longint'(v_wave_gain)) >>> 14);
        res.u_out = clamp_byte(u);
        res.v_out = clamp_byte(v);
        return res;
    endfunction

    // Print the first few mismatches, count them all
    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Mostly random, with a bias towards the ends of the range
    function automatic int unsigned pick_field(int unsigned top);
        case ($urandom_range(0, 7))
            0: return 0;
            1: return top;
            default: return $urandom_range(0, top);
        endcase
    endfunction

    function automatic t_in random_pair();
        t_in b;
        b.luma_first    = 8'(pick_field(255));
        b.luma_second   = 8'(pick_field(255));
        b.chroma_column = 11'(pick_field(2047));
        b.luma_row      = 12'(pick_field(4095));
        return b;
    endfunction

    function automatic t_in make_pair(int y1, int y2, int x, int r);
        t_in b;
        b.luma_first    = 8'(y1);
        b.luma_second   = 8'(y2);
        b.chroma_column = 11'(x);
        b.luma_row      = 12'(r);
        return b;
    endfunction

    // Write all four gains in order; valid stays high across the beats
    task automatic write_gains(input logic [8:0] vals [4]);
        t_cfg_reg idx;
        for (int k = 0; k < 4; k++) begin
            idx = t_cfg_reg'(k);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx)
                REG_U_WAVE_GAIN: u_wave_gain = vals[k][7:0];
                REG_V_WAVE_GAIN: v_wave_gain = vals[k][7:0];
                REG_U_DIFF_GAIN: u_diff_gain = vals[k];
                REG_V_DIFF_GAIN: v_diff_gain = vals[k];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Driver: record the accepted beat, then present the next one or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_data  <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_chroma.push_back(synth_chroma(i_data));
                beats_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_data  <= pending_pairs.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_chroma.size() == 0) begin
                    report_mismatch("result beat with nothing pending", int'(o_data), 0);
                end else begin
                    want = expected_chroma.pop_front();
                    beats_checked++;
                    if (o_data.u_out !== want.u_out) begin
                        report_mismatch("u_out", int'(o_data.u_out), int'(want.u_out));
                    end
                    if (o_data.v_out !== want.v_out) begin
                        report_mismatch("v_out", int'(o_data.v_out), int'(want.v_out));
                    end
                end
            end
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Stimulus: one gain setting per phase, directed pairs first, then random ones
    initial begin
        logic [8:0] gains [4];
        fill_wave_lut();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int ph = 0; ph < PHASES; ph++) begin
            // Sender idles lightly first, then the receiver, then neither
            case (ph / 2)
                0: begin send_idle_pct = 10; recv_idle_pct = 76; end
                1: begin send_idle_pct = 76; recv_idle_pct = 10; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (ph)
                0: ; // run on the reset gains
                1: begin gains = '{9'h1FF, 9'h1FF, 9'd511, 9'd511}; write_gains(gains); end
                2: begin gains = '{9'h100, 9'h000, 9'd0, 9'd0};     write_gains(gains); end
                5: begin gains = '{9'd255, 9'd0, 9'd0, 9'd511};     write_gains(gains); end
                default: begin
                    foreach (gains[k]) gains[k] = 9'($urandom_range(0, 511));
                    write_gains(gains);
                end
            endcase
            if (ph == 0) begin
                // Field extremes, clamping both ways, sign of the V phase slope, phase wrap
                pending_pairs.push_back(make_pair(0, 0, 0, 0));
                pending_pairs.push_back(make_pair(255, 255, 2047, 4095));
                pending_pairs.push_back(make_pair(255, 0, 0, 0));
                pending_pairs.push_back(make_pair(0, 255, 0, 0));
                pending_pairs.push_back(make_pair(255, 0, 2047, 4095));
                pending_pairs.push_back(make_pair(0, 255, 2047, 4095));
                pending_pairs.push_back(make_pair(128, 128, 0, 4095));
                pending_pairs.push_back(make_pair(128, 128, 2047, 0));
                pending_pairs.push_back(make_pair(200, 10, 1023, 2048));
                pending_pairs.push_back(make_pair(10, 200, 614, 2047));
                pending_pairs.push_back(make_pair(77, 77, 3, 10));
                pending_pairs.push_back(make_pair(1, 0, 1, 1));
                pending_pairs.push_back(make_pair(254, 255, 2046, 4094));
                pending_pairs.push_back(make_pair(255, 255, 0, 0));
                pending_pairs.push_back(make_pair(0, 0, 2047, 4095));
                pending_pairs.push_back(make_pair(170, 85, 1365, 2730));
                pending_pairs.push_back(make_pair(85, 170, 682, 1365));
            end
            repeat (RANDOM_PER_PHASE) pending_pairs.push_back(random_pair());
            beats_queued = beats_queued + pending_pairs.size();
            // Drain fully before the next gain change: every queued beat checked
            while (beats_checked != beats_queued) begin
                @(posedge i_clk);
            end
        end
        // Let the five-stage pipeline settle; a stray beat would show up here
        repeat (20) @(posedge i_clk);
        $display("Checked %0d of %0d luma pairs over %0d gain settings,", beats_checked,
                 beats_sent, PHASES);
        $display("with sender and receiver stalls mixed in turn and %0d mismatches.", mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Hang guard: far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("Timed out with %0d results outstanding", expected_chroma.size());
        $display("FAILURE");
        $finish;
    end

endmodule

[luma_driven_wave_chroma.f]
src/ldwc_pkg.sv
src/ldwc_phase.sv
src/ldwc_sine_rom.sv
src/ldwc_mix.sv
src/luma_driven_wave_chroma.sv
tb/luma_driven_wave_chroma_tb.sv
